// File: rtl/nsfc_pkg.sv
package nsfc_pkg;

  // default sizes
  localparam int LINE_CAPACITY_DEF = 80;
  localparam int QUEUE_DEPTH_DEF   = 4;
  localparam int LEN_W             = 8;
  localparam int CH_W              = 7;

  // line checks
  localparam int MIN_LEN   = 9;
  localparam int TAIL_LEN  = 3;
  localparam int COMMA_POS = 6;
  localparam int ID_LEN    = 5;

  // ascii codes
  localparam logic [CH_W-1:0] ASC_DOLLAR = 7'h24;
  localparam logic [CH_W-1:0] ASC_LF     = 7'h0a;
  localparam logic [CH_W-1:0] ASC_CR     = 7'h0d;
  localparam logic [CH_W-1:0] ASC_STAR   = 7'h2a;
  localparam logic [CH_W-1:0] ASC_COMMA  = 7'h2c;
  localparam logic [CH_W-1:0] ASC_SPACE  = 7'h20;
  localparam logic [CH_W-1:0] ASC_TAB    = 7'h09;
  localparam logic [CH_W-1:0] ASC_VT     = 7'h0b;
  localparam logic [CH_W-1:0] ASC_FF     = 7'h0c;
  localparam logic [CH_W-1:0] ASC_PLUS   = 7'h2b;
  localparam logic [CH_W-1:0] ASC_MINUS  = 7'h2d;
  localparam logic [CH_W-1:0] ASC_ZERO   = 7'h30;
  localparam logic [CH_W-1:0] ASC_NINE   = 7'h39;
  localparam logic [CH_W-1:0] ASC_LC_A   = 7'h61;
  localparam logic [CH_W-1:0] ASC_LC_F   = 7'h66;
  localparam logic [CH_W-1:0] ASC_UC_A   = 7'h41;
  localparam logic [CH_W-1:0] ASC_UC_F   = 7'h46;
  localparam logic [CH_W-1:0] ASC_LC_X   = 7'h78;
  localparam logic [CH_W-1:0] ASC_UC_X   = 7'h58;

  // sentence status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_OVERFLOW  = 3'd1,
    ST_TOO_SHORT = 3'd2,
    ST_NO_STAR   = 3'd3,
    ST_STAR_POS  = 3'd4,
    ST_CHECKSUM  = 3'd5,
    ST_TALKER    = 3'd6
  } status_t;

  // character class found by the front end
  typedef enum logic [2:0] {
    CLS_OTHER  = 3'd0,
    CLS_DOLLAR = 3'd1,
    CLS_LF     = 3'd2,
    CLS_CR     = 3'd3,
    CLS_STAR   = 3'd4,
    CLS_COMMA  = 3'd5
  } char_cls_t;

  // queued word between front and back
  typedef struct packed {
    logic            restart;
    char_cls_t       cls;
    logic [CH_W-1:0] ch;
  } item_t;

  // result word, status in the low bits
  typedef struct packed {
    logic [3*CH_W-1:0] sentence_id;
    logic [2*CH_W-1:0] talker_id;
    logic              valid_res;
    logic              done_res;
    logic [2:0]        status;
  } result_t;

  // hex digit value, msb set when the character is a digit
  function automatic logic [4:0] hex_digit(input logic [CH_W-1:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= ASC_ZERO && c <= ASC_NINE) begin
      r = {1'b1, 4'(c - ASC_ZERO)};
    end else if (c >= ASC_LC_A && c <= ASC_LC_F) begin
      r = {1'b1, 4'(c - ASC_LC_A + 7'd10)};
    end else if (c >= ASC_UC_A && c <= ASC_UC_F) begin
      r = {1'b1, 4'(c - ASC_UC_A + 7'd10)};
    end
    return r;
  endfunction

  // base-16 parse of the two trailing characters, compared with the xor
  function automatic logic checksum_ok(input logic [CH_W-1:0] c0,
                                       input logic [CH_W-1:0] c1,
                                       input logic [CH_W-1:0] x);
    logic [4:0] d0;
    logic [4:0] d1;
    logic [7:0] mag;
    logic       neg;
    logic       lead_space;
    d0  = hex_digit(c0);
    d1  = hex_digit(c1);
    mag = 8'd0;
    neg = 1'b0;
    lead_space = (c0 == ASC_SPACE) || (c0 == ASC_TAB) || (c0 == ASC_VT) ||
                 (c0 == ASC_FF) || (c0 == ASC_LF) || (c0 == ASC_CR);
    if (lead_space) begin
      mag = d1[4] ? {4'd0, d1[3:0]} : 8'd0;
    end else if (c0 == ASC_PLUS || c0 == ASC_MINUS) begin
      neg = (c0 == ASC_MINUS);
      mag = d1[4] ? {4'd0, d1[3:0]} : 8'd0;
    end else if (d0[4]) begin
      if (c0 == ASC_ZERO && (c1 == ASC_LC_X || c1 == ASC_UC_X)) begin
        mag = 8'd0;
      end else if (d1[4]) begin
        mag = {d0[3:0], d1[3:0]};
      end else begin
        mag = {4'd0, d0[3:0]};
      end
    end
    if (neg) begin
      return (mag == 8'd0) && (x == '0);
    end
    return mag == {1'b0, x};
  endfunction

endpackage

// File: rtl/nsfc_front.sv
module nsfc_front (
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,  // [6:0] ch, [7] zero
  input  logic                   s_axis_tuser,  // [0] operation
  input  logic                   queue_full,
  output logic                   push,
  output nsfc_pkg::item_t        push_item
);

  logic [nsfc_pkg::CH_W-1:0] ch;

  assign ch = s_axis_tdata[nsfc_pkg::CH_W-1:0];

  // accept while the queue has room
  assign s_axis_tready = !queue_full;
  assign push          = s_axis_tvalid && !queue_full;

  // classify the incoming character
  always_comb begin
    push_item.restart = s_axis_tuser;
    push_item.ch      = ch;
    case (ch)
      nsfc_pkg::ASC_DOLLAR: push_item.cls = nsfc_pkg::CLS_DOLLAR;
      nsfc_pkg::ASC_LF:     push_item.cls = nsfc_pkg::CLS_LF;
      nsfc_pkg::ASC_CR:     push_item.cls = nsfc_pkg::CLS_CR;
      nsfc_pkg::ASC_STAR:   push_item.cls = nsfc_pkg::CLS_STAR;
      nsfc_pkg::ASC_COMMA:  push_item.cls = nsfc_pkg::CLS_COMMA;
      default:              push_item.cls = nsfc_pkg::CLS_OTHER;
    endcase
  end

endmodule

// File: rtl/nsfc_queue.sv
module nsfc_queue #(
  parameter int DEPTH = nsfc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  nsfc_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output nsfc_pkg::item_t pop_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  nsfc_pkg::item_t  entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_item = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/nsfc_back.sv
module nsfc_back #(
  parameter int LINE_CAPACITY = nsfc_pkg::LINE_CAPACITY_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    empty,
  input  nsfc_pkg::item_t         item,
  output logic                    pop,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output nsfc_pkg::result_t       result
);

  localparam int LEN_W = nsfc_pkg::LEN_W;
  localparam int CH_W  = nsfc_pkg::CH_W;

  // sentence state
  logic                 started, started_next;
  logic                 finished, finished_next;
  nsfc_pkg::status_t    error_code, error_code_next;
  logic [LEN_W-1:0]     line_length, line_length_next;
  logic [CH_W-1:0]      running_xor, running_xor_next;
  logic                 star_seen, star_seen_next;
  logic [LEN_W-1:0]     star_index, star_index_next;
  logic                 comma_seen, comma_seen_next;
  logic [LEN_W-1:0]     comma_index, comma_index_next;
  logic [CH_W-1:0]      id_letters [nsfc_pkg::ID_LEN];
  logic [CH_W-1:0]      id_letters_next [nsfc_pkg::ID_LEN];
  logic [CH_W-1:0]      last_two [2];
  logic [CH_W-1:0]      last_two_next [2];

  logic                 line_full;
  logic                 do_store;
  nsfc_pkg::status_t    check_code;
  nsfc_pkg::result_t    result_next;
  logic                 valid_next;

  // take a word when the output register is free or being drained
  assign pop = !empty && (!m_axis_tvalid || m_axis_tready);

  assign line_full = (line_length >= LEN_W'(LINE_CAPACITY));

  // a byte after '$' other than CR or LF goes into the line while it has room, and so does the '$' itself
  always_comb begin
    do_store = 1'b0;
    if (!item.restart && !finished) begin
      if (started) begin
        do_store = !line_full && item.cls != nsfc_pkg::CLS_LF &&
                   item.cls != nsfc_pkg::CLS_CR;
      end else begin
        do_store = (item.cls == nsfc_pkg::CLS_DOLLAR);
      end
    end
  end

  // end-of-line checks on the collected line
  always_comb begin
    if (line_length < LEN_W'(nsfc_pkg::MIN_LEN)) begin
      check_code = nsfc_pkg::ST_TOO_SHORT;
    end else if (!star_seen) begin
      check_code = nsfc_pkg::ST_NO_STAR;
    end else if (star_index != line_length - LEN_W'(nsfc_pkg::TAIL_LEN)) begin
      check_code = nsfc_pkg::ST_STAR_POS;
    end else if (!nsfc_pkg::checksum_ok(last_two[0], last_two[1], running_xor)) begin
      check_code = nsfc_pkg::ST_CHECKSUM;
    end else if (!comma_seen || comma_index != LEN_W'(nsfc_pkg::COMMA_POS)) begin
      check_code = nsfc_pkg::ST_TALKER;
    end else begin
      check_code = nsfc_pkg::ST_OK;
    end
  end

  // next state
  always_comb begin
    started_next     = started;
    finished_next    = finished;
    error_code_next  = error_code;
    line_length_next = line_length;
    running_xor_next = running_xor;
    star_seen_next   = star_seen;
    star_index_next  = star_index;
    comma_seen_next  = comma_seen;
    comma_index_next = comma_index;
    id_letters_next  = id_letters;
    last_two_next    = last_two;
    if (item.restart) begin
      started_next     = 1'b0;
      finished_next    = 1'b0;
      error_code_next  = nsfc_pkg::ST_OK;
      line_length_next = '0;
      running_xor_next = '0;
      star_seen_next   = 1'b0;
      star_index_next  = '0;
      comma_seen_next  = 1'b0;
      comma_index_next = '0;
      for (int i = 0; i < nsfc_pkg::ID_LEN; i++) begin
        id_letters_next[i] = '0;
      end
      last_two_next[0] = '0;
      last_two_next[1] = '0;
    end else if (!finished) begin
      if (!started && item.cls == nsfc_pkg::CLS_DOLLAR) begin
        started_next = 1'b1;
      end
      if (started && line_full) begin
        error_code_next = nsfc_pkg::ST_OVERFLOW;
      end else if (started && item.cls == nsfc_pkg::CLS_LF) begin
        finished_next   = 1'b1;
        error_code_next = check_code;
      end
      if (do_store) begin
        for (int i = 0; i < nsfc_pkg::ID_LEN; i++) begin
          if (line_length == LEN_W'(i + 1)) begin
            id_letters_next[i] = item.ch;
          end
        end
        if (line_length != '0 && !star_seen) begin
          if (item.cls == nsfc_pkg::CLS_STAR) begin
            star_seen_next  = 1'b1;
            star_index_next = line_length;
          end else begin
            running_xor_next = running_xor ^ item.ch;
          end
        end
        if (item.cls == nsfc_pkg::CLS_COMMA && !comma_seen) begin
          comma_seen_next  = 1'b1;
          comma_index_next = line_length;
        end
        last_two_next[0] = last_two[1];
        last_two_next[1] = item.ch;
        line_length_next = line_length + 1'b1;
      end
    end
  end

  // result word from the updated state
  always_comb begin
    valid_next              = finished_next && (error_code_next == nsfc_pkg::ST_OK);
    result_next.status      = error_code_next;
    result_next.done_res    = finished_next;
    result_next.valid_res   = valid_next;
    result_next.talker_id   = valid_next ? {id_letters[0], id_letters[1]} : '0;
    result_next.sentence_id = valid_next ?
                              {id_letters[2], id_letters[3], id_letters[4]} : '0;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      started     <= 1'b0;
      finished    <= 1'b0;
      error_code  <= nsfc_pkg::ST_OK;
      line_length <= '0;
      running_xor <= '0;
      star_seen   <= 1'b0;
      star_index  <= '0;
      comma_seen  <= 1'b0;
      comma_index <= '0;
      for (int i = 0; i < nsfc_pkg::ID_LEN; i++) begin
        id_letters[i] <= '0;
      end
      last_two[0] <= '0;
      last_two[1] <= '0;
    end else if (pop) begin
      started     <= started_next;
      finished    <= finished_next;
      error_code  <= error_code_next;
      line_length <= line_length_next;
      running_xor <= running_xor_next;
      star_seen   <= star_seen_next;
      star_index  <= star_index_next;
      comma_seen  <= comma_seen_next;
      comma_index <= comma_index_next;
      id_letters  <= id_letters_next;
      last_two    <= last_two_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (pop) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result <= result_next;
    end
  end

endmodule

// File: rtl/nmea_sentence_frame_check.sv
// NMEA sentence framing and checksum check.
// Input stream: one word per received character; tdata[6:0] carries the
// ASCII byte, tuser[0] set means restart (clear all sentence state).
// Output stream: exactly one result word for every input word, in order,
// restart words included. tdata packs status, done, valid, the two talker
// letters and the three sentence-type letters, lowest first.
// Characters before '$' are ignored, CR is dropped, LF closes the line and
// the length, '*' position, checksum and first-comma position are checked.
// From input acceptance to output tvalid a word passes the queue and then
// the output register: the front end classifies combinationally and writes
// the queue at the accepting edge, and the back end pops the word into the
// output register. Throughput is one word per cycle while the receiver
// does not stall the output register.
// When the receiver stalls, the output register holds its word and the
// queue (QUEUE_DEPTH words) keeps absorbing input until it fills, then
// s_axis_tready drops. Reset clears the queue, the output tvalid and the
// sentence state; no output word is pending after reset.
module nmea_sentence_frame_check #(
  parameter int LINE_CAPACITY = nsfc_pkg::LINE_CAPACITY_DEF,
  parameter int QUEUE_DEPTH   = nsfc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [6:0] ch, [7] zero
  input  logic        s_axis_tuser,   // [0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // [2:0] status, [3] done_res, [4] valid_res,
                                      // [18:5] talker_id, [39:19] sentence_id
);

  logic              queue_full;
  logic              queue_empty;
  logic              push;
  logic              pop;
  nsfc_pkg::item_t   push_item;
  nsfc_pkg::item_t   pop_item;
  nsfc_pkg::result_t result;

  // classify and accept
  nsfc_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .queue_full    (queue_full),
    .push          (push),
    .push_item     (push_item)
  );

  // decoupling queue
  nsfc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .empty     (queue_empty),
    .pop_item  (pop_item)
  );

  // sentence state and result
  nsfc_back #(
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .empty         (queue_empty),
    .item          (pop_item),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .result        (result)
  );

  assign m_axis_tdata = result;

endmodule

// File: rtl/nsfc_checker.sv
module nsfc_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  logic [2:0] status;
  logic       done_res;
  logic       valid_res;

  assign status    = m_axis_tdata[2:0];
  assign done_res  = m_axis_tdata[3];
  assign valid_res = m_axis_tdata[4];

  // no word pending right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output word pending after reset");

  // valid only for a finished line with ok status
  a_valid_ok: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && valid_res |-> done_res && status == nsfc_pkg::ST_OK)
    else $error("valid_res without a clean finished line");

  // letters are zero unless the line is valid
  a_ids_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !valid_res |-> m_axis_tdata[39:5] == '0)
    else $error("id letters shown on an invalid line");

  // before the line ends only overflow can be flagged
  a_open_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !done_res |->
      status == nsfc_pkg::ST_OK || status == nsfc_pkg::ST_OVERFLOW)
    else $error("line check status before end of line");

  // stalled output word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

endmodule

bind nmea_sentence_frame_check nsfc_checker u_nsfc_checker (.*);
